/* rtl/core/abp_pkg.sv */
// shared types and constants for the alphabet symbol to byte packer
// used by the front classifier, the transaction queue, the back end and the top level
package abp_pkg;

	localparam int BYTE_W  = 8;
	localparam int PEND_W  = 7;
	localparam int CNT_W   = 3;
	localparam int CFG_W   = 4;
	localparam int SUM_W   = 4;
	localparam int ACC_W   = PEND_W + BYTE_W;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	localparam logic [CFG_W-1:0] BITS_RESET = 4'd3;

	localparam logic [1:0] OP_DECODE = 2'd0;
	localparam logic [1:0] OP_FLUSH  = 2'd1;
	localparam logic [1:0] OP_LOAD   = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	typedef enum logic [1:0] {
		K_DECODE,
		K_FLUSH,
		K_LOAD
	} kind_t;

	// one classified transaction waiting for the back end
	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] index;
	} q_entry_t;

	typedef struct packed {
		logic             scanning;
		logic [CNT_W-1:0] pend_cnt;
	} back_status_t;

endpackage

/* rtl/core/abp_if.sv */
// channel interfaces of the alphabet symbol to byte packer
// input items, result items and the configuration write channel; no dependencies
interface abp_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] letter;
	logic [7:0] entry_index;
	logic [7:0] entry_char;

	modport source (output valid, op, letter, entry_index, entry_char, input ready);
	modport sink (input valid, op, letter, entry_index, entry_char, output ready);
endinterface

interface abp_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       is_flush;
	logic [2:0] pad_bits;

	modport source (output valid, out_byte, has_byte, is_flush, pad_bits, input ready);
	modport sink (input valid, out_byte, has_byte, is_flush, pad_bits, output ready);
endinterface

interface abp_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/core/abp_front.sv */
// front end: accepts input transactions and classifies them for the back end
// depends on abp_pkg and abp_item_if
module abp_front
	import abp_pkg::*;
(
	abp_item_if.sink   item,
	input  logic       q_full,
	output logic       push,
	output q_entry_t   entry
);

	logic known_op;

	assign item.ready = !q_full;

	always_comb begin
		known_op    = 1'b1;
		entry.kind  = K_DECODE;
		entry.data  = item.letter;
		entry.index = item.entry_index;
		unique case (item.op)
			OP_DECODE: begin
				entry.kind = K_DECODE;
				entry.data = item.letter;
			end
			OP_FLUSH: begin
				entry.kind = K_FLUSH;
			end
			OP_LOAD: begin
				entry.kind = K_LOAD;
				entry.data = item.entry_char;
			end
			default: begin
				// unused code is taken and dropped
				known_op = 1'b0;
			end
		endcase
	end

	assign push = item.valid && !q_full && known_op;

endmodule

/* rtl/core/abp_queue.sv */
// short fifo of classified transactions between front and back end
// depends on abp_pkg
module abp_queue
	import abp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output logic     vld,
	output q_entry_t head
);

	q_entry_t             slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign full = count_q == Q_CNT_W'(Q_DEPTH);
	assign vld  = count_q != '0;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

/* rtl/core/abp_back.sv */
// back end: alphabet memory, sequential reverse lookup, bit accumulator and result register
// depends on abp_pkg and abp_result_if
module abp_back
	import abp_pkg::*;
#(
	parameter int MAX_SYMBOL_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CFG_W-1:0]  n_bits,
	input  logic              q_vld,
	input  q_entry_t          q_head,
	output logic              q_pop,
	abp_result_if.source      result,
	output back_status_t      status
);

	localparam int AW    = MAX_SYMBOL_BITS;
	localparam int DEPTH = 1 << AW;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t                state_q;
	logic [BYTE_W-1:0]     mem [DEPTH];
	logic [AW-1:0]         addr_q;
	logic                  issued_q;
	logic [BYTE_W-1:0]     letter_q;
	logic [BYTE_W-1:0]     data_s1;
	logic [AW-1:0]         idx_s1;
	logic                  vld_s1;
	logic [PEND_W-1:0]     pend_q;
	logic [CNT_W-1:0]      pend_cnt_q;
	logic                  out_vld_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic                  has_byte_q;
	logic                  is_flush_q;
	logic [CNT_W-1:0]      pad_q;

	logic                  out_free;
	logic                  mem_we;
	logic                  mem_re;
	logic                  in_range;
	logic [AW:0]           size;
	logic [AW-1:0]         last_idx;
	logic                  hit;
	logic                  miss;
	logic [ACC_W-1:0]      acc;
	logic [SUM_W-1:0]      cnt_sum;
	logic                  full_byte;
	logic [SUM_W-1:0]      rem_cnt;
	logic [PEND_W-1:0]     rem_mask;
	logic [BYTE_W-1:0]     pack_byte;
	logic [CNT_W-1:0]      flush_pad;
	logic [BYTE_W-1:0]     flush_byte;

	assign out_free = !out_vld_q || result.ready;
	assign q_pop    = (state_q == ST_IDLE) && q_vld && out_free;
	assign in_range = (q_head.index >> AW) == '0;
	assign mem_we   = q_pop && (q_head.kind == K_LOAD) && in_range;
	assign mem_re   = (state_q == ST_SCAN) && !issued_q;

	assign size     = (AW + 1)'(1) << n_bits;
	assign last_idx = AW'(size - 1'b1);

	assign hit  = (state_q == ST_SCAN) && vld_s1 && (data_s1 == letter_q);
	assign miss = (state_q == ST_SCAN) && vld_s1 && !hit && (idx_s1 == last_idx);

	// append the matched index below the pending bits
	assign acc       = ({{BYTE_W{1'b0}}, pend_q} << n_bits) | ACC_W'(idx_s1);
	assign cnt_sum   = SUM_W'(pend_cnt_q) + n_bits;
	assign full_byte = cnt_sum >= SUM_W'(BYTE_W);
	assign rem_cnt   = full_byte ? cnt_sum - SUM_W'(BYTE_W) : cnt_sum;
	assign rem_mask  = PEND_W'((BYTE_W'(1) << rem_cnt) - 1'b1);
	assign pack_byte = BYTE_W'(acc >> rem_cnt);

	// left-align leftover bits; an empty accumulator gives pad 0 and byte 0
	assign flush_pad  = CNT_W'(SUM_W'(BYTE_W) - SUM_W'(pend_cnt_q));
	assign flush_byte = (pend_cnt_q == '0) ? '0 : BYTE_W'({1'b0, pend_q} << flush_pad);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_head.index[AW-1:0]] <= q_head.data;
		end
		if (mem_re) begin
			data_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			addr_q     <= '0;
			issued_q   <= 1'b0;
			letter_q   <= '0;
			idx_s1     <= '0;
			vld_s1     <= 1'b0;
			pend_q     <= '0;
			pend_cnt_q <= '0;
			out_vld_q  <= 1'b0;
			out_byte_q <= '0;
			has_byte_q <= 1'b0;
			is_flush_q <= 1'b0;
			pad_q      <= '0;
		end else begin
			if (out_vld_q && result.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_head.kind)
							K_DECODE: begin
								state_q  <= ST_SCAN;
								letter_q <= q_head.data;
								addr_q   <= '0;
								issued_q <= 1'b0;
								vld_s1   <= 1'b0;
							end
							K_FLUSH: begin
								out_vld_q  <= 1'b1;
								out_byte_q <= flush_byte;
								has_byte_q <= pend_cnt_q != '0;
								is_flush_q <= 1'b1;
								pad_q      <= (pend_cnt_q == '0) ? '0 : flush_pad;
								pend_q     <= '0;
								pend_cnt_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// one memory read per cycle, compared in the cycle after the read
					vld_s1 <= !issued_q;
					idx_s1 <= addr_q;
					if (!issued_q) begin
						addr_q   <= addr_q + 1'b1;
						issued_q <= addr_q == last_idx;
					end
					if (hit) begin
						state_q    <= ST_IDLE;
						vld_s1     <= 1'b0;
						pend_q     <= PEND_W'(acc) & rem_mask;
						pend_cnt_q <= CNT_W'(rem_cnt);
						if (full_byte) begin
							out_vld_q  <= 1'b1;
							out_byte_q <= pack_byte;
							has_byte_q <= 1'b1;
							is_flush_q <= 1'b0;
							pad_q      <= '0;
						end
					end else if (miss) begin
						state_q <= ST_IDLE;
						vld_s1  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid    = out_vld_q;
	assign result.out_byte = out_byte_q;
	assign result.has_byte = has_byte_q;
	assign result.is_flush = is_flush_q;
	assign result.pad_bits = pad_q;

	assign status.scanning = state_q == ST_SCAN;
	assign status.pend_cnt = pend_cnt_q;

endmodule

/* rtl/core/alphabet_symbol_to_byte_packer.sv */
// load: written to memory when popped; flush: loaded into the result register when popped;
// decode: reads from index 0 through the single read port of the alphabet memory up to the
// lowest match, or to entry 2^n - 1 with no match; one transaction at a time in the back end;
// loads and flushes one per cycle while the result register is free; 2-deep queue in front
// reset: arst_n clears queue, accumulator, result register and sets bits_per_symbol to 3;
// the alphabet memory is not cleared; top level, depends on abp_pkg, abp_if and submodules
module alphabet_symbol_to_byte_packer
	import abp_pkg::*;
#(
	parameter int MAX_SYMBOL_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	abp_item_if.sink      item,
	abp_result_if.source  result,
	abp_cfg_if.sink       cfg
);

	logic [CFG_W-1:0] bits_q;
	logic [CFG_W-1:0] n_bits;
	logic             push;
	q_entry_t         push_entry;
	logic             q_full;
	logic             q_pop;
	logic             q_vld;
	q_entry_t         q_head;
	back_status_t     status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= BITS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			bits_q <= cfg.data;
		end
	end

	// zero acts as one, anything above the maximum acts as the maximum
	always_comb begin
		if (bits_q == '0) begin
			n_bits = CFG_W'(1);
		end else if (bits_q > CFG_W'(MAX_SYMBOL_BITS)) begin
			n_bits = CFG_W'(MAX_SYMBOL_BITS);
		end else begin
			n_bits = bits_q;
		end
	end

	abp_front u_front (
		.item   (item),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	abp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.vld        (q_vld),
		.head       (q_head)
	);

	abp_back #(
		.MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.n_bits (n_bits),
		.q_vld  (q_vld),
		.q_head (q_head),
		.q_pop  (q_pop),
		.result (result),
		.status (status)
	);

	// the result register stays empty for the whole lookup
	a_scan_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		status.scanning |-> !result.valid)
		else $error("result pending during lookup");

	// a new flush transaction leaves the accumulator empty
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) && result.is_flush |-> status.pend_cnt == '0)
		else $error("accumulator not cleared by flush");

	// a decode transaction always carries a full byte with no padding
	a_decode_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) && !result.is_flush |-> result.has_byte && result.pad_bits == '0)
		else $error("decode transaction without full byte");

	// nothing is pulled from the queue while a lookup is in progress
	a_no_pop_scan: assert property (@(posedge clk) disable iff (!arst_n)
		status.scanning |-> !q_pop)
		else $error("queue popped during lookup");

endmodule

/* test/alphabet_symbol_to_byte_packer_tb.sv */
// testbench for alphabet_symbol_to_byte_packer: a directed table, then random traffic over
// several symbol widths; results checked against fixed table rows or a packing predictor
// depends on abp_pkg, abp_if and the packer rtl
module alphabet_symbol_to_byte_packer_tb
	import abp_pkg::*;
();

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 6;
	localparam int MAX_WIDTH    = 8;
	localparam int SCAN_SETTLE  = 1024;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 75;
	localparam int PLAN_LEN     = 13;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] letter;
		logic [7:0] entry_index;
		logic [7:0] entry_char;
	} sym_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       is_flush;
		logic [2:0] pad_bits;
	} byte_result_t;

	typedef struct packed {
		sym_item_t    item;
		logic         fixed;
		byte_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	abp_item_if   item_ch();
	abp_result_if res_ch();
	abp_cfg_if    cfg_ch();

	alphabet_symbol_to_byte_packer uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	// predictor state
	logic [7:0] alpha_mem [256];
	logic [6:0] pend_bits;
	logic [2:0] pend_cnt;
	logic [3:0] width_reg;

	byte_result_t pending_bytes [$];
	stim_row_t    dir_rows [$];
	byte_result_t seen_want;

	int width_plan [PLAN_LEN] = '{3, 1, 8, 0, 15, 2, 4, 5, 6, 7, 12, 8, 1};

	int  mismatches = 0;
	int  n_items = 0;
	int  n_bytes = 0;
	int  n_flushes = 0;
	int  n_dropped = 0;
	int  idle_cycles = 0;
	int  burst_left = 1;
	bit  gaps_on = 1'b1;
	bit  hold_req = 1'b0;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	function automatic int eff_width();
		int n;
		n = int'(width_reg);
		if (n < 1) n = 1;
		if (n > MAX_WIDTH) n = MAX_WIDTH;
		return n;
	endfunction

	// advances the predictor by one transaction; returns 1 when a result is due
	function automatic bit pack_step(input sym_item_t it, output byte_result_t r);
		int n;
		int idx;
		int cnt;
		int i;
		logic [15:0] acc;
		r = '0;
		case (it.op)
		OP_DECODE: begin
			n = eff_width();
			idx = -1;
			for (i = 0; i < (1 << n); i++)
				if (idx < 0 && alpha_mem[8'(i)] == it.letter) idx = i;
			if (idx < 0) begin
				n_dropped++;
				return 1'b0;
			end
			acc = (16'(pend_bits) << n) | 16'(idx);
			cnt = int'(pend_cnt) + n;
			if (cnt >= 8) begin
				r.out_byte = 8'(acc >> (cnt - 8));
				r.has_byte = 1'b1;
				cnt -= 8;
			end
			pend_cnt = 3'(cnt);
			pend_bits = 7'(acc & ((16'd1 << cnt) - 16'd1));
			return r.has_byte;
		end
		OP_FLUSH: begin
			if (pend_cnt != 0) begin
				r.pad_bits = 3'(8 - int'(pend_cnt));
				r.out_byte = {1'b0, pend_bits} << r.pad_bits;
				r.has_byte = 1'b1;
			end
			r.is_flush = 1'b1;
			pend_bits = '0;
			pend_cnt = '0;
			return 1'b1;
		end
		OP_LOAD: begin
			alpha_mem[it.entry_index] = it.entry_char;
			return 1'b0;
		end
		default: return 1'b0;
		endcase
	endfunction

	function automatic sym_item_t make_item();
		sym_item_t it;
		int pick;
		it.op = OP_DECODE;
		it.letter = 8'($urandom_range(0, 255));
		it.entry_index = 8'($urandom_range(0, 255));
		it.entry_char = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		// mostly letters known to the current alphabet, so bytes keep coming
		if (pick < 72) begin
			it.letter = alpha_mem[8'($urandom_range(0, (1 << eff_width()) - 1))];
		end else if (pick >= 97) begin
			it.op = OP_NONE;
		end else if (pick >= 89) begin
			it.op = OP_LOAD;
			if ($urandom_range(0, 1))
				it.entry_index = 8'($urandom_range(0, (1 << eff_width()) - 1));
		end else if (pick >= 80) begin
			it.op = OP_FLUSH;
		end
		return it;
	endfunction

	task automatic add_row(input logic [1:0] op, input logic [7:0] letter,
			input logic [7:0] eidx, input logic [7:0] echar, input logic fixed,
			input logic [7:0] out_byte, input logic has, input logic fl, input logic [2:0] pad);
		stim_row_t row;
		row.item = '{op, letter, eidx, echar};
		row.fixed = fixed;
		row.want = '{out_byte, has, fl, pad};
		dir_rows.push_back(row);
	endtask

	task automatic offer_item(input sym_item_t it, input logic fixed, input byte_result_t want);
		byte_result_t r;
		bit got;
		int gap;
		item_ch.valid <= 1'b1;
		item_ch.op <= it.op;
		item_ch.letter <= it.letter;
		item_ch.entry_index <= it.entry_index;
		item_ch.entry_char <= it.entry_char;
		do @(posedge clk); while (!item_ch.ready);
		n_items++;
		got = pack_step(it, r);
		if (fixed)
			pending_bytes.push_back(want);
		else if (got)
			pending_bytes.push_back(r);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap != 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	// up to three decodes without a result may still be queued or scanning
	task automatic write_width(input logic [3:0] value);
		drain_results();
		repeat (SCAN_SETTLE) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		width_reg = value;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// result sink: random stall pattern (always ready, periodic or random ready), long hold-off on request
	initial begin
		int mode;
		int period;
		int tick;
		res_ch.ready <= 1'b0;
		mode = 0;
		period = 3;
		tick = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			tick++;
			if (tick % 128 == 0) begin
				mode = $urandom_range(0, 2);
				period = $urandom_range(2, 9);
			end
			case (mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= (tick % period) != 0;
			default: res_ch.ready <= $urandom_range(0, 9) < 3;
			endcase
		end
	end

	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected: byte %0d has %0d flush %0d pad %0d",
					$time, res_ch.out_byte, res_ch.has_byte, res_ch.is_flush, res_ch.pad_bits);
			end else begin
				seen_want = pending_bytes.pop_front();
				check_field("out_byte", int'(seen_want.out_byte), int'(res_ch.out_byte));
				check_field("has_byte", int'(seen_want.has_byte), int'(res_ch.has_byte));
				check_field("is_flush", int'(seen_want.is_flush), int'(res_ch.is_flush));
				check_field("pad_bits", int'(seen_want.pad_bits), int'(res_ch.pad_bits));
				if (res_ch.has_byte) n_bytes++;
				if (res_ch.is_flush) n_flushes++;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		sym_item_t it;
		int ph;
		int k;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.op <= OP_DECODE;
		item_ch.letter <= '0;
		item_ch.entry_index <= '0;
		item_ch.entry_char <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		pend_bits = '0;
		pend_cnt = '0;
		width_reg = BITS_RESET;

		// directed table, width 3 after reset
		add_row(OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 3'd0);
		add_row(OP_LOAD, 8'h00, 8'd0, 8'h41, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_LOAD, 8'h00, 8'd1, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_LOAD, 8'h00, 8'd2, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_LOAD, 8'h00, 8'd3, 8'h41, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_LOAD, 8'h00, 8'd4, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_LOAD, 8'h00, 8'd5, 8'h7F, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_LOAD, 8'h00, 8'd6, 8'h55, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_LOAD, 8'h00, 8'd7, 8'hAA, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_LOAD, 8'h00, 8'd255, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_DECODE, 8'hAA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		// letter absent from the alphabet is dropped
		add_row(OP_DECODE, 8'h42, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_DECODE, 8'hAA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		// 0x41 sits at 0 and 3, lowest wins
		add_row(OP_DECODE, 8'h41, 8'h00, 8'h00, 1'b1, 8'hFC, 1'b1, 1'b0, 3'd0);
		add_row(OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b1, 3'd7);
		add_row(OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 3'd0);
		add_row(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_DECODE, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_DECODE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_DECODE, 8'h7F, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_DECODE, 8'h80, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_DECODE, 8'h55, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_DECODE, 8'hAA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);
		add_row(OP_DECODE, 8'h55, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < dir_rows.size(); k++)
			offer_item(dir_rows[k].item, dir_rows[k].fixed, dir_rows[k].want);

		// fill the whole alphabet so no scan ever reads an unwritten entry;
		// small characters repeat often so the lowest-index rule matters
		for (k = 0; k < 256; k++) begin
			it.op = OP_LOAD;
			it.letter = 8'($urandom_range(0, 255));
			it.entry_index = 8'(k);
			it.entry_char = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
				: 8'($urandom_range(0, 255));
			offer_item(it, 1'b0, '0);
		end

		for (ph = 0; ph < PLAN_LEN; ph++) begin
			write_width(4'(width_plan[ph]));
			gaps_on = (ph % 3) != 0;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k == 10 && (ph == 3 || ph == 9)) hold_req = 1'b1;
				if (k == 40 && ph == 5) drain_results();
				offer_item(make_item(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (SCAN_SETTLE) @(posedge clk);
		$display("%0d transactions over %0d width settings, widths 0 and 15 clamped",
			n_items, PLAN_LEN);
		$display("%0d bytes out, %0d flushes, %0d letters dropped, %0d mismatching fields",
			n_bytes, n_flushes, n_dropped, mismatches);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/abp_pkg.sv
rtl/core/abp_if.sv
rtl/core/abp_front.sv
rtl/core/abp_queue.sv
rtl/core/abp_back.sv
rtl/core/alphabet_symbol_to_byte_packer.sv
test/alphabet_symbol_to_byte_packer_tb.sv
